/* rtl/core/tks_pkg.sv */
// tks_pkg: shared types and constants for the top-k score selector
// holds the input and result word structs and the fixed field widths
// no dependencies
`default_nettype none

package tks_pkg;

  // fixed field widths
  localparam int unsigned ScoreW    = 16;
  localparam int unsigned IndexOutW = 10;
  localparam int unsigned KCountW   = 7;

  // k_count value after reset
  localparam logic [KCountW-1:0] KCountReset = 7'd1;

  // one input word: a score and the end-of-set mark
  typedef struct packed {
    logic [ScoreW-1:0] score;
    logic              last_in;
  } in_word_t;

  // one result word: selected position and final-selection flag
  typedef struct packed {
    logic [IndexOutW-1:0] picked_index;
    logic                 last_out;
  } out_word_t;

endpackage

`default_nettype wire

/* rtl/core/top_k_score_select.sv */
// top_k_score_select: picks the K largest scores of a loaded set, one index per pass
// depends on tks_pkg for the word structs and field widths
//
// loading accepts a word whenever start is high while busy is low; after the word marked last,
// busy rises and K passes run, each pass reading the n stored scores in turn (one store
// read per cycle through the single compare unit), then draining the read register;
// n = set size; the word of each pass is registered from its drain state onto res_o
// busy stays high through all K passes; the receiver cannot stall, so words never wait
// reset clears the control state and sets k_count to 1; the score store needs no clearing
`default_nettype none

module top_k_score_select #(
  parameter int unsigned MAX_ITEMS = 1024,
  parameter int unsigned MAX_K     = 64
) (
  input  wire                                clk_i,
  input  wire                                rst_ni,
  input  wire                                start,
  output logic                               busy,
  input  tks_pkg::in_word_t                  in_i,
  input  wire                                cfg_we_i,
  input  wire  [tks_pkg::KCountW-1:0]        cfg_wdata_i,
  output logic                               res_strobe_o,
  output tks_pkg::out_word_t                 res_o
);

  import tks_pkg::*;

  localparam int unsigned IW   = (MAX_ITEMS > 1) ? $clog2(MAX_ITEMS) : 1;
  localparam int unsigned FW   = $clog2(MAX_ITEMS + 1);
  localparam int unsigned KW   = (MAX_K > 1) ? $clog2(MAX_K) : 1;
  localparam int unsigned KeyW = ScoreW + IW;

  typedef enum logic [1:0] {
    ST_LOAD,
    ST_SCAN,
    ST_DRAIN
  } state_e;

  state_e                state_q;
  logic [FW-1:0]         fill_q;
  logic [KCountW-1:0]    k_count_q;
  logic [KW-1:0]         k_last_q;
  logic [KW-1:0]         pass_q;
  logic [IW-1:0]         last_addr_q;
  logic [IW-1:0]         rd_addr_q;
  logic [IW-1:0]         rd_idx_q;
  logic                  rd_vld_q;
  logic [ScoreW-1:0]     rd_data_q;
  logic                  best_vld_q;
  logic [KeyW-1:0]       best_key_q;
  logic                  has_bound_q;
  logic [KeyW-1:0]       bound_key_q;
  logic                  res_valid_q;
  out_word_t             res_q;

  logic [ScoreW-1:0]     mem [MAX_ITEMS];

  logic                  accept;
  logic                  store_full;
  logic [KeyW-1:0]       cand_key;
  logic                  cand_take;
  logic                  fin_vld;
  logic [KeyW-1:0]       fin_key;
  logic [IW-1:0]         pick_idx;
  logic [IW+IndexOutW-1:0] pick_ext;
  logic [KW-1:0]         k_last;

  assign busy       = (state_q != ST_LOAD);
  assign accept     = start && !busy;
  assign store_full = (fill_q >= FW'(MAX_ITEMS));

  // effective k minus one: zero acts as one, large values clamp to MAX_K
  always_comb begin
    if (k_count_q == '0) begin
      k_last = '0;
    end else if (k_count_q > KCountW'(MAX_K)) begin
      k_last = KW'(MAX_K - 1);
    end else begin
      k_last = KW'(k_count_q - KCountW'(1));
    end
  end

  // shared compare unit: best key below the previous pick, keys are {score, index}
  assign cand_key  = {rd_data_q, rd_idx_q};
  assign cand_take = rd_vld_q
                     && (!has_bound_q || (cand_key < bound_key_q))
                     && (!best_vld_q || (cand_key > best_key_q));
  assign fin_vld   = cand_take || best_vld_q;
  assign fin_key   = cand_take ? cand_key : best_key_q;

  // pass result, repeating the previous pick once the set is exhausted
  assign pick_idx = fin_vld ? fin_key[IW-1:0] : bound_key_q[IW-1:0];
  assign pick_ext = {{IndexOutW{1'b0}}, pick_idx};

  // score store: one write port for loading, one registered read port for scanning
  always_ff @(posedge clk_i) begin
    if (accept && !store_full) begin
      mem[fill_q[IW-1:0]] <= in_i.score;
    end
    rd_data_q <= mem[rd_addr_q];
  end

  // sequencer and registered outputs
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_LOAD;
      fill_q      <= '0;
      k_count_q   <= KCountReset;
      k_last_q    <= '0;
      pass_q      <= '0;
      last_addr_q <= '0;
      rd_addr_q   <= '0;
      rd_idx_q    <= '0;
      rd_vld_q    <= 1'b0;
      best_vld_q  <= 1'b0;
      best_key_q  <= '0;
      has_bound_q <= 1'b0;
      bound_key_q <= '0;
      res_valid_q <= 1'b0;
      res_q       <= '0;
    end else begin
      res_valid_q <= (state_q == ST_DRAIN);
      rd_vld_q    <= (state_q == ST_SCAN);
      rd_idx_q    <= rd_addr_q;

      // config write
      if (cfg_we_i) begin
        k_count_q <= cfg_wdata_i;
      end

      // running best of the current pass, cleared when the pass ends
      if (state_q == ST_DRAIN) begin
        best_vld_q <= 1'b0;
      end else if (cand_take) begin
        best_vld_q <= 1'b1;
      end
      if (cand_take) begin
        best_key_q <= cand_key;
      end

      unique case (state_q)
        ST_LOAD: begin
          if (accept) begin
            if (in_i.last_in) begin
              // set closes: start the first pass
              last_addr_q <= store_full ? IW'(MAX_ITEMS - 1) : fill_q[IW-1:0];
              k_last_q    <= k_last;
              pass_q      <= '0;
              has_bound_q <= 1'b0;
              bound_key_q <= '0;
              rd_addr_q   <= '0;
              fill_q      <= '0;
              state_q     <= ST_SCAN;
            end else if (!store_full) begin
              fill_q <= fill_q + FW'(1);
            end
          end
        end
        ST_SCAN: begin
          rd_addr_q <= rd_addr_q + IW'(1);
          if (rd_addr_q == last_addr_q) begin
            state_q <= ST_DRAIN;
          end
        end
        ST_DRAIN: begin
          // last compare of the pass, emit its word
          res_q.picked_index <= pick_ext[IndexOutW-1:0];
          res_q.last_out     <= (pass_q == k_last_q);
          if (fin_vld) begin
            bound_key_q <= fin_key;
            has_bound_q <= 1'b1;
          end
          rd_addr_q  <= '0;
          pass_q     <= pass_q + KW'(1);
          if (pass_q == k_last_q) begin
            state_q <= ST_LOAD;
          end else begin
            state_q <= ST_SCAN;
          end
        end
        default: begin
          state_q <= ST_LOAD;
        end
      endcase
    end
  end

  assign res_strobe_o = res_valid_q;
  assign res_o        = res_q;

endmodule

`default_nettype wire
